### hw/rtl/utf8_to_utf16le_transcoder_core_macros.svh
// Assertion macros shared by the transcoder queue and back modules
`ifndef UTF8_TO_UTF16LE_TRANSCODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16LE_TRANSCODER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define U8T_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define U8T_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/u8t_pkg.sv
// Types, constants and decode functions of the UTF-8 to UTF-16LE transcoder
package u8t_pkg;

    // Capacity saturation limit in bytes
    localparam logic [10:0] MAX_CAPACITY_BYTES = 11'd1024;

    // Configuration register index
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
    localparam logic [15:0] SURR_HI_BASE   = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE   = 16'hDC00;

    // One decoded event for the back part: a code point or an end marker
    typedef struct packed {
        logic        is_end;
        logic [20:0] cp;
    } t_evt;

    // Event with its valid flag, as it moves through the queue
    typedef struct packed {
        logic valid;
        t_evt evt;
    } t_push;

    // Sequence length fixed by a lead byte; 0 if it cannot start one
    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] len;
        priority if (c[7] == 1'b0)             len = 3'd1;
        else if (c[7:5] == 3'b110)             len = 3'd2;
        else if (c[7:4] == 4'b1110)            len = 3'd3;
        else if (c[7:3] == 5'b11110)           len = 3'd4;
        else                                   len = 3'd0;
        return len;
    endfunction

    // Assemble a code point from up to four bytes, continuation bits masked
    function automatic logic [20:0] decode(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [2:0] len
    );
        logic [20:0] cp;
        unique case (len)
            3'd1:    cp = {13'b0, b0};
            3'd2:    cp = {10'b0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: cp = CP_REPLACEMENT;
        endcase
        return cp;
    endfunction

endpackage

### hw/rtl/utf8_to_utf16le_transcoder_core.sv
// Top level of the UTF-8 to UTF-16LE transcoder with its register port
//
//  Channel  | Direction | Payload
//  s_axis   | in        | tdata text_byte, tuser has_byte, tlast end_of_string
//  m_axis   | out       | tdata code_unit/total_bytes, tuser unit_valid/output_full,
//           |           | tlast last_of_string
//  apb      | in/out    | capacity_bytes at byte address 0
//
//  One byte item per cycle unless stalled; an accepted byte passes through the
//  event queue and the result register before its first result item is offered.
//  A completed 4-byte sequence above 0xFFFF yields two items (surrogate pair).
//  Input stalls while the queue is full, and at end of string while the front
//  queues the events of any held bytes left over and then the end marker.
//  Synchronous active-low reset; capacity resets to 512 bytes.
//  The FIFO_DEPTH-entry event queue lets input flow while output stalls.
module utf8_to_utf16le_transcoder_core
    import u8t_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    input  logic        i_s_axis_tuser,   // [0] has_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] code_unit, [26:16] total_bytes
    output logic [1:0]  o_m_axis_tuser,   // [0] unit_valid, [1] output_full
    output logic        o_m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [10:0] r_capacity;
    t_push       push;
    t_push       head;
    logic        q_full;
    logic        pop;
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        output_full;
    logic [10:0] total_bytes;
    logic        cfg_wr;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? {21'b0, r_capacity} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 11'd512;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[10:0];
        end
    end

    u8t_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_has_byte      (i_s_axis_tuser),
        .i_text_byte     (i_s_axis_tdata),
        .i_end_of_string (i_s_axis_tlast),
        .i_q_full        (q_full),
        .o_push          (push)
    );

    u8t_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    u8t_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_capacity    (r_capacity),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_code_unit   (code_unit),
        .o_unit_valid  (unit_valid),
        .o_last        (o_m_axis_tlast),
        .o_output_full (output_full),
        .o_total_bytes (total_bytes)
    );

    // Pack result fields
    assign o_m_axis_tdata = {5'b0, total_bytes, code_unit};
    assign o_m_axis_tuser = {output_full, unit_valid};

endmodule

### hw/rtl/u8t_front.sv
// Front part: accepts UTF-8 bytes, gathers sequences and queues code points
module u8t_front
    import u8t_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_has_byte,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_string,
    input  logic       i_q_full,
    output t_push      o_push
);

    logic [7:0] r_held [3];
    logic [7:0] n_held [3];
    logic [1:0] r_count, n_count;
    logic       r_tail, n_tail;

    logic       acc;
    logic [2:0] lead_len;
    logic [2:0] byte_len;
    logic [7:0] b1, b2;
    logic       main_v;
    logic [20:0] main_cp;
    logic [1:0] consume;

    assign o_ready  = !r_tail && !i_q_full;
    assign acc      = i_valid && o_ready;
    assign lead_len = seq_len(r_held[0]);
    assign byte_len = seq_len(i_text_byte);
    assign b1       = (r_count == 2'd1) ? i_text_byte : r_held[1];
    assign b2       = (r_count == 2'd2) ? i_text_byte : r_held[2];

    // Gather bytes, then drain held bytes one event per cycle at string end while the queue is not full
    always_comb begin
        n_held  = r_held;
        n_count = r_count;
        n_tail  = r_tail;
        main_v  = 1'b0;
        main_cp = CP_REPLACEMENT;
        consume = 2'd1;
        o_push  = '0;

        if (acc && i_has_byte) begin
            if (r_count == 2'd0) begin
                if (byte_len <= 3'd1) begin
                    main_v  = 1'b1;
                    main_cp = (byte_len == 3'd1) ? {13'b0, i_text_byte} : CP_REPLACEMENT;
                end else begin
                    n_held[0] = i_text_byte;
                    n_count   = 2'd1;
                end
            end else if ({1'b0, r_count} + 3'd1 >= lead_len) begin
                main_v  = 1'b1;
                main_cp = decode(r_held[0], b1, b2, i_text_byte, lead_len);
                n_count = 2'd0;
            end else begin
                n_held[r_count] = i_text_byte;
                n_count         = r_count + 2'd1;
            end
        end

        if (acc) begin
            if (main_v) begin
                o_push.valid  = 1'b1;
                o_push.evt.cp = main_cp;
            end
            if (i_end_of_string) begin
                if (!main_v && n_count == 2'd0) begin
                    o_push.valid      = 1'b1;
                    o_push.evt.is_end = 1'b1;
                end else begin
                    n_tail = 1'b1;
                end
            end
        end

        // Re-decode held bytes from their start, shifting them down
        if (r_tail && !i_q_full) begin
            o_push.valid = 1'b1;
            if (r_count == 2'd0) begin
                o_push.evt.is_end = 1'b1;
                n_tail            = 1'b0;
            end else begin
                if (lead_len == 3'd2 && r_count >= 2'd2) begin
                    o_push.evt.cp = decode(r_held[0], r_held[1], 8'h00, 8'h00, 3'd2);
                    consume       = 2'd2;
                end else if (lead_len == 3'd3 && r_count == 2'd3) begin
                    o_push.evt.cp = decode(r_held[0], r_held[1], r_held[2], 8'h00, 3'd3);
                    consume       = 2'd3;
                end else begin
                    o_push.evt.cp = (lead_len == 3'd1) ? {13'b0, r_held[0]} : CP_REPLACEMENT;
                    consume       = 2'd1;
                end
                n_held[0] = (consume == 2'd1) ? r_held[1] : r_held[2];
                n_held[1] = r_held[2];
                n_count   = r_count - consume;
            end
        end
    end

    // Held bytes carry no reset
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_tail  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_tail  <= n_tail;
        end
    end

endmodule

### hw/rtl/u8t_queue.sv
// Short queue of decoded events between the front and back parts
`include "utf8_to_utf16le_transcoder_core_macros.svh"

module u8t_queue
    import u8t_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output t_push o_head,
    input  logic  i_pop
);

    localparam int AW = $clog2(DEPTH);

    t_evt         r_mem [DEPTH];
    logic [AW:0]  r_wr, r_rd;

    assign o_full = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_head.valid = (r_wr != r_rd);
    assign o_head.evt   = r_mem[r_rd[AW-1:0]];

    // Store pushed events
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr[AW-1:0]] <= i_push.evt;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + (AW+1)'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + (AW+1)'(1);
            end
        end
    end

    `U8T_ASSERT_IMPL(a_no_push_when_full, i_push.valid, !o_full, "push into full queue")
    `U8T_ASSERT_IMPL(a_no_pop_when_empty, i_pop, o_head.valid, "pop from empty queue")

endmodule

### hw/rtl/u8t_back.sv
// Back part: checks capacity, splits surrogate pairs and drives result items
`include "utf8_to_utf16le_transcoder_core_macros.svh"

module u8t_back
    import u8t_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [10:0] i_capacity,
    input  t_push       i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code_unit,
    output logic        o_unit_valid,
    output logic        o_last,
    output logic        o_output_full,
    output logic [10:0] o_total_bytes
);

    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_unit, n_out_unit;
    logic        r_out_uvalid, n_out_uvalid;
    logic        r_out_last, n_out_last;
    logic        r_out_full, n_out_full;
    logic [10:0] r_out_total, n_out_total;
    logic [10:0] r_bytes, n_bytes;
    logic        r_stopped, n_stopped;
    logic        r_low_pend, n_low_pend;
    logic [15:0] r_low_unit, n_low_unit;

    logic        can_load;
    logic [10:0] cap_eff;
    logic        big;
    logic [11:0] sum;
    logic [11:0] sum2;
    logic [20:0] v;

    assign can_load = !r_out_valid || i_ready;
    assign cap_eff  = (i_capacity > MAX_CAPACITY_BYTES) ? MAX_CAPACITY_BYTES : i_capacity;
    assign big      = (i_head.evt.cp[20:16] != 5'd0);
    assign sum      = {1'b0, r_bytes} + (big ? 12'd4 : 12'd2);
    assign sum2     = {1'b0, r_bytes} + 12'd2;
    assign v        = i_head.evt.cp - CP_SUPP_BASE;
    assign o_pop    = can_load && !r_low_pend && i_head.valid;

    // Emit one result per cycle while the receiver is ready; drop code points once output is full
    always_comb begin
        n_out_valid  = r_out_valid && !i_ready;
        n_out_unit   = r_out_unit;
        n_out_uvalid = r_out_uvalid;
        n_out_last   = r_out_last;
        n_out_full   = r_out_full;
        n_out_total  = r_out_total;
        n_bytes      = r_bytes;
        n_stopped    = r_stopped;
        n_low_pend   = r_low_pend;
        n_low_unit   = r_low_unit;

        if (can_load && r_low_pend) begin
            n_out_valid  = 1'b1;
            n_out_unit   = r_low_unit;
            n_out_uvalid = 1'b1;
            n_out_last   = 1'b0;
            n_out_full   = r_stopped;
            n_out_total  = sum2[10:0];
            n_bytes      = sum2[10:0];
            n_low_pend   = 1'b0;
        end else if (o_pop) begin
            if (i_head.evt.is_end) begin
                n_out_valid  = 1'b1;
                n_out_unit   = 16'h0000;
                n_out_uvalid = 1'b0;
                n_out_last   = 1'b1;
                n_out_full   = r_stopped;
                n_out_total  = r_bytes;
                n_bytes      = 11'd0;
                n_stopped    = 1'b0;
            end else if (!r_stopped) begin
                if (sum > {1'b0, cap_eff}) begin
                    n_stopped = 1'b1;
                end else begin
                    n_out_valid  = 1'b1;
                    n_out_uvalid = 1'b1;
                    n_out_last   = 1'b0;
                    n_out_full   = 1'b0;
                    n_out_total  = sum2[10:0];
                    n_bytes      = sum2[10:0];
                    if (big) begin
                        n_out_unit = SURR_HI_BASE + {5'b0, v[20:10]};
                        n_low_unit = SURR_LO_BASE + {6'b0, v[9:0]};
                        n_low_pend = 1'b1;
                    end else begin
                        n_out_unit = i_head.evt.cp[15:0];
                    end
                end
            end
        end
    end

    // Output payload and pending low unit carry no reset
    always_ff @(posedge i_clk) begin
        r_out_unit   <= n_out_unit;
        r_out_uvalid <= n_out_uvalid;
        r_out_last   <= n_out_last;
        r_out_full   <= n_out_full;
        r_out_total  <= n_out_total;
        r_low_unit   <= n_low_unit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_bytes     <= 11'd0;
            r_stopped   <= 1'b0;
            r_low_pend  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_bytes     <= n_bytes;
            r_stopped   <= n_stopped;
            r_low_pend  <= n_low_pend;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_code_unit   = r_out_unit;
    assign o_unit_valid  = r_out_uvalid;
    assign o_last        = r_out_last;
    assign o_output_full = r_out_full;
    assign o_total_bytes = r_out_total;

    // High unit lies in 0xD800..0xDFBF, since code points above 0x10FFFF are kept
    `U8T_ASSERT_IMPL(a_low_follows_high, r_low_pend,
        r_out_valid && r_out_unit[15:11] == 5'b11011, "low surrogate without high")
    `U8T_ASSERT_IMPL(a_low_not_stopped, r_low_pend, !r_stopped, "pair split by full output")
    `U8T_ASSERT_IMPL(a_total_even, r_out_valid, !r_out_total[0], "odd byte total")
    `U8T_ASSERT_NEXT(a_end_clears, o_pop && i_head.evt.is_end,
        r_out_valid && r_out_last && r_bytes == 11'd0 && !r_stopped, "end marker not issued")

endmodule
